// ----- rtl/quaternion_to_euler_degrees_defines.svh -----
// Assertion macros for the quaternion to Euler angle block.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_TO_EULER_DEGREES_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("q2e assertion failed");
`define Q2E_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("q2e latency assertion failed");
`else
`define Q2E_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define Q2E_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons)
`endif
`endif

// ----- rtl/q2e_pkg.sv -----
// Shared constants, widths and the CORDIC arctangent table for the
// quaternion to Euler angle block. No dependencies.
package q2e_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_DEF = 7;
  localparam int ITERS_DEF      = 16;

  localparam int BASE_W   = 16;  // component width the product sums are sized for
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 35;
  localparam int P_SPLIT  = 17;  // low slice of p for the gain multiply
  localparam int GAIN_W   = 31;
  localparam int MUL_W    = SUM_W - P_SPLIT + GAIN_W + 1;
  localparam int PK_W     = SUM_W + GAIN_W + 1;
  localparam int PK_SHIFT = 10;
  localparam int OP_FRAC  = 20;
  localparam int OP_W     = 58;
  localparam int ANG_W    = 26;
  localparam int Z_FRAC   = 16;  // CORDIC angle: degrees * 2^16

  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

  function automatic logic signed [ANG_W-1:0] atan_deg16(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/quaternion_to_euler_degrees.sv -----
// Top level: quaternion (w,x,y,z) to roll, pitch, yaw in degrees.
// Depends on q2e_pkg, q2e_cordic and quaternion_to_euler_degrees_defines.svh.
//
// Fully pipelined: one quaternion may be started every cycle and busy is
// only high during reset. Each result appears with out_valid exactly
// 2*CORDIC_ITERS+7 cycles after its start beat (39 at the default 16
// steps) and must be taken in that cycle; there is no back-pressure. The
// latency is set by two CORDIC pipelines in series: roll and yaw run side
// by side, then pitch uses the roll magnitude as its x operand. Before
// them sit four stages: products, sums, the gain multiply split in two
// halves, and their recombination; one rounding stage follows.
`include "quaternion_to_euler_degrees_defines.svh"
module quaternion_to_euler_degrees #(
  parameter int COMP_WIDTH      = q2e_pkg::COMP_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_DEF,
  parameter int CORDIC_ITERS    = q2e_pkg::ITERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COMP_WIDTH-1:0]        in_comp_w,
  input  logic signed [COMP_WIDTH-1:0]        in_comp_x,
  input  logic signed [COMP_WIDTH-1:0]        in_comp_y,
  input  logic signed [COMP_WIDTH-1:0]        in_comp_z,
  output logic                                out_valid,
  output logic signed [q2e_pkg::ROLL_W-1:0]   out_roll_deg,
  output logic signed [q2e_pkg::PITCH_W-1:0]  out_pitch_deg,
  output logic signed [q2e_pkg::YAW_W-1:0]    out_yaw_deg,
  output logic                                out_pitch_clamped,
  output logic                                out_zero_norm
);

  localparam int PROD_SHIFT = (COMP_WIDTH > q2e_pkg::BASE_W) ?
                              2 * (COMP_WIDTH - q2e_pkg::BASE_W) : 0;
  localparam int OUT_SHIFT  = q2e_pkg::Z_FRAC - ANGLE_FRAC_BITS;
  localparam int LATENCY    = 2 * CORDIC_ITERS + 7;
  localparam int ANG_W      = q2e_pkg::ANG_W;
  localparam int SUM_W      = q2e_pkg::SUM_W;
  localparam int OP_W       = q2e_pkg::OP_W;
  localparam logic signed [ANG_W-1:0] LIM180 = ANG_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [ANG_W-1:0] LIM90  = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [ANG_W-1:0] RND    = ANG_W'(1 << (OUT_SHIFT - 1));
  localparam logic [q2e_pkg::PITCH_W-1:0] P90_OUT = LIM90[q2e_pkg::PITCH_W-1:0];
  localparam logic signed [ANG_W-1:0] NLIM90 = -LIM90;
  localparam logic [q2e_pkg::PITCH_W-1:0] N90_OUT = NLIM90[q2e_pkg::PITCH_W-1:0];

  function automatic logic signed [q2e_pkg::PROD_W-1:0] prod(
    input logic signed [COMP_WIDTH-1:0] a,
    input logic signed [COMP_WIDTH-1:0] b
  );
    logic signed [2*COMP_WIDTH-1:0] pf;
    pf = a * b;
    pf = pf >>> PROD_SHIFT;
    return q2e_pkg::PROD_W'(pf);
  endfunction

  function automatic logic signed [ANG_W-1:0] to_out(
    input logic signed [ANG_W-1:0] z,
    input logic signed [ANG_W-1:0] lim
  );
    logic signed [ANG_W-1:0] r;
    r = (z + RND) >>> OUT_SHIFT;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // stage 1: products
  logic v1_r, zero1_r;
  logic signed [q2e_pkg::PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wy_r, zx_r, wz_r, xy_r;

  always_ff @(posedge clk) begin
    ww_r    <= prod(in_comp_w, in_comp_w);
    xx_r    <= prod(in_comp_x, in_comp_x);
    yy_r    <= prod(in_comp_y, in_comp_y);
    zz_r    <= prod(in_comp_z, in_comp_z);
    wx_r    <= prod(in_comp_w, in_comp_x);
    yz_r    <= prod(in_comp_y, in_comp_z);
    wy_r    <= prod(in_comp_w, in_comp_y);
    zx_r    <= prod(in_comp_z, in_comp_x);
    wz_r    <= prod(in_comp_w, in_comp_z);
    xy_r    <= prod(in_comp_x, in_comp_y);
    zero1_r <= (in_comp_w == '0) && (in_comp_x == '0) &&
               (in_comp_y == '0) && (in_comp_z == '0);
  end

  // stage 2: sums
  logic v2_r, zero2_r;
  logic signed [SUM_W-1:0] n2_r, a2_r, b2_r, p2_r, c2_r, d2_r;
  logic signed [SUM_W-1:0] sww, sxx, syy, szz;

  always_comb begin
    sww = SUM_W'(ww_r);
    sxx = SUM_W'(xx_r);
    syy = SUM_W'(yy_r);
    szz = SUM_W'(zz_r);
  end

  always_ff @(posedge clk) begin
    zero2_r <= zero1_r;
    n2_r    <= sww + sxx + syy + szz;
    b2_r    <= sww + szz - sxx - syy;
    d2_r    <= sww + sxx - syy - szz;
    a2_r    <= (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
    p2_r    <= (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
    c2_r    <= (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
  end

  // stage 3: gimbal test, gain multiply in two halves
  logic v3_r, zero3_r, clamp3_r, psign3_r;
  logic signed [SUM_W-1:0] a3_r, b3_r, c3_r, d3_r;
  logic signed [q2e_pkg::MUL_W-1:0] ml3_r, mh3_r;
  logic signed [SUM_W-1:0] absp2;
  logic signed [q2e_pkg::GAIN_W:0] gain_s;

  assign absp2  = (p2_r < 0) ? -p2_r : p2_r;
  assign gain_s = $signed({1'b0, q2e_pkg::GAIN_Q30});

  always_ff @(posedge clk) begin
    zero3_r  <= zero2_r;
    clamp3_r <= absp2 >= n2_r;
    psign3_r <= p2_r[SUM_W-1];
    a3_r     <= a2_r;
    b3_r     <= b2_r;
    c3_r     <= c2_r;
    d3_r     <= d2_r;
    ml3_r    <= q2e_pkg::MUL_W'($signed({1'b0, p2_r[q2e_pkg::P_SPLIT-1:0]}) * gain_s);
    mh3_r    <= q2e_pkg::MUL_W'($signed(p2_r[SUM_W-1:q2e_pkg::P_SPLIT]) * gain_s);
  end

  // stage 4: recombine pitch operand
  logic v4_r, zero4_r, clamp4_r, psign4_r;
  logic signed [SUM_W-1:0] a4_r, b4_r, c4_r, d4_r;
  logic signed [OP_W-1:0] pk4_r;
  logic signed [q2e_pkg::PK_W-1:0] pk_full;

  assign pk_full = (q2e_pkg::PK_W'(mh3_r) <<< q2e_pkg::P_SPLIT) + q2e_pkg::PK_W'(ml3_r);

  always_ff @(posedge clk) begin
    zero4_r  <= zero3_r;
    clamp4_r <= clamp3_r;
    psign4_r <= psign3_r;
    a4_r     <= a3_r;
    b4_r     <= b3_r;
    c4_r     <= c3_r;
    d4_r     <= d3_r;
    pk4_r    <= OP_W'(pk_full >>> q2e_pkg::PK_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // roll and yaw CORDICs
  localparam int RSB_W = OP_W + 3;
  logic signed [OP_W-1:0] a_op, b_op, c_op, d_op;
  logic [RSB_W-1:0] roll_sb_in, roll_sb_out;
  logic roll_valid;
  logic signed [ANG_W-1:0] roll_z, yaw_z;
  logic signed [OP_W-1:0] roll_mag;

  assign a_op = OP_W'(a4_r) <<< q2e_pkg::OP_FRAC;
  assign b_op = OP_W'(b4_r) <<< q2e_pkg::OP_FRAC;
  assign c_op = OP_W'(c4_r) <<< q2e_pkg::OP_FRAC;
  assign d_op = OP_W'(d4_r) <<< q2e_pkg::OP_FRAC;
  assign roll_sb_in = {pk4_r, clamp4_r, psign4_r, zero4_r};

  q2e_cordic #(.ITERS(CORDIC_ITERS), .SB_W(RSB_W)) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_x      (b_op),
    .in_y      (a_op),
    .in_sb     (roll_sb_in),
    .out_valid (roll_valid),
    .out_z     (roll_z),
    .out_mag   (roll_mag),
    .out_sb    (roll_sb_out)
  );

  q2e_cordic #(.ITERS(CORDIC_ITERS), .SB_W(1)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_x      (d_op),
    .in_y      (c_op),
    .in_sb     (1'b0),
    .out_valid (),
    .out_z     (yaw_z),
    .out_mag   (),
    .out_sb    ()
  );

  // pitch CORDIC: asin via atan2(p * gain, hypot from roll)
  localparam int PSB_W = 2 * ANG_W + 3;
  logic signed [OP_W-1:0] pk5;
  logic [PSB_W-1:0] pit_sb_in, pit_sb_out;
  logic pit_valid;
  logic signed [ANG_W-1:0] pit_z;

  assign pk5       = roll_sb_out[RSB_W-1:3];
  assign pit_sb_in = {roll_z, yaw_z, roll_sb_out[2:0]};

  q2e_cordic #(.ITERS(CORDIC_ITERS), .SB_W(PSB_W)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (roll_valid),
    .in_x      (roll_mag),
    .in_y      (pk5),
    .in_sb     (pit_sb_in),
    .out_valid (pit_valid),
    .out_z     (pit_z),
    .out_mag   (),
    .out_sb    (pit_sb_out)
  );

  // output stage: round, saturate, special cases
  logic signed [ANG_W-1:0] roll_f, yaw_f, pitch_f, rz6, yz6;
  logic clamp6, psign6, zero6;
  logic out_valid_r, out_clamp_r, out_zero_r;
  logic signed [q2e_pkg::ROLL_W-1:0]  out_roll_r;
  logic signed [q2e_pkg::PITCH_W-1:0] out_pitch_r;
  logic signed [q2e_pkg::YAW_W-1:0]   out_yaw_r;

  always_comb begin
    rz6    = pit_sb_out[PSB_W-1:ANG_W+3];
    yz6    = pit_sb_out[ANG_W+2:3];
    clamp6 = pit_sb_out[2];
    psign6 = pit_sb_out[1];
    zero6  = pit_sb_out[0];
    roll_f = to_out(rz6, LIM180);
    yaw_f  = to_out(yz6, LIM180);
    if (clamp6) begin
      pitch_f = psign6 ? -LIM90 : LIM90;
    end else begin
      pitch_f = to_out(pit_z, LIM90);
    end
    if (zero6) begin
      roll_f  = '0;
      yaw_f   = '0;
      pitch_f = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pit_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_roll_r  <= roll_f[q2e_pkg::ROLL_W-1:0];
    out_pitch_r <= pitch_f[q2e_pkg::PITCH_W-1:0];
    out_yaw_r   <= yaw_f[q2e_pkg::YAW_W-1:0];
    out_clamp_r <= clamp6 & ~zero6;
    out_zero_r  <= zero6;
  end

  assign out_valid         = out_valid_r;
  assign out_roll_deg      = out_roll_r;
  assign out_pitch_deg     = out_pitch_r;
  assign out_yaw_deg       = out_yaw_r;
  assign out_pitch_clamped = out_clamp_r;
  assign out_zero_norm     = out_zero_r;

  `Q2E_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LATENCY, out_valid)
  `Q2E_ASSERT_IMP(a_no_orphan, clk, rst_n, out_valid, $past(start && !busy, LATENCY))
  `Q2E_ASSERT_IMP(a_zero_out, clk, rst_n, out_valid && out_zero_norm, out_roll_deg == '0 && out_pitch_deg == '0 && out_yaw_deg == '0 && !out_pitch_clamped)
  `Q2E_ASSERT_IMP(a_clamp_pitch, clk, rst_n, out_valid && out_pitch_clamped, out_pitch_deg == P90_OUT || out_pitch_deg == N90_OUT)

endmodule

// ----- rtl/q2e_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) in degrees * 2^16 plus the
// gain-scaled magnitude. One pre-rotation stage, then one stage per step.
// Depends on q2e_pkg.
module q2e_cordic #(
  parameter int ITERS = q2e_pkg::ITERS_DEF,
  parameter int SB_W  = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [q2e_pkg::OP_W-1:0]   in_x,
  input  logic signed [q2e_pkg::OP_W-1:0]   in_y,
  input  logic [SB_W-1:0]                   in_sb,
  output logic                              out_valid,
  output logic signed [q2e_pkg::ANG_W-1:0]  out_z,
  output logic signed [q2e_pkg::OP_W-1:0]   out_mag,
  output logic [SB_W-1:0]                   out_sb
);

  logic signed [q2e_pkg::OP_W-1:0]  x_r  [0:ITERS];
  logic signed [q2e_pkg::OP_W-1:0]  y_r  [0:ITERS];
  logic signed [q2e_pkg::ANG_W-1:0] z_r  [0:ITERS];
  logic                             v_r  [0:ITERS];
  logic                             zf_r [0:ITERS];
  logic [SB_W-1:0]                  sb_r [0:ITERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ITERS; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 0; i < ITERS; i++) v_r[i+1] <= v_r[i];
    end
  end

  // left half-plane folds over by 180 degrees
  always_ff @(posedge clk) begin
    zf_r[0] <= (in_x == '0) && (in_y == '0);
    sb_r[0] <= in_sb;
    if (in_x < 0) begin
      x_r[0] <= -in_x;
      y_r[0] <= -in_y;
      z_r[0] <= (in_y >= 0) ? q2e_pkg::DEG180 : -q2e_pkg::DEG180;
    end else begin
      x_r[0] <= in_x;
      y_r[0] <= in_y;
      z_r[0] <= '0;
    end
    for (int i = 0; i < ITERS; i++) begin
      zf_r[i+1] <= zf_r[i];
      sb_r[i+1] <= sb_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + q2e_pkg::atan_deg16(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - q2e_pkg::atan_deg16(i);
      end
    end
  end

  assign out_valid = v_r[ITERS];
  assign out_z     = zf_r[ITERS] ? '0 : z_r[ITERS];
  assign out_mag   = x_r[ITERS];
  assign out_sb    = sb_r[ITERS];

endmodule
